// File: rtl/sprite_quad_vertex_transform_top_defines.svh
// ----------------------------------------------------------------------------
// sprite quad vertex transform assertion macros
// shared property wrappers for the checker, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_TRANSFORM_TOP_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication
`define SPQVT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQVT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spqvt_pkg.sv
// ----------------------------------------------------------------------------
// sprite quad vertex transform package
// constants, register codes, angle folding and the quarter-wave sine table
// ----------------------------------------------------------------------------
package spqvt_pkg;

    localparam int COORD_FRACTION_BITS_DEF = 4;

    localparam int QUARTER_TURN = 1440;
    localparam int QUO_BITS     = 16;
    localparam int DIV_STAGES   = QUO_BITS + 1;

    localparam logic [12:0] ANGLE_Q1   = 13'd1440;
    localparam logic [12:0] ANGLE_Q2   = 13'd2880;
    localparam logic [12:0] ANGLE_Q3   = 13'd4320;
    localparam logic [12:0] ANGLE_FULL = 13'd5760;

    localparam logic [12:0] SCREEN_WIDTH_RST   = 13'd1280;
    localparam logic [12:0] SCREEN_HEIGHT_RST  = 13'd720;
    localparam logic [13:0] TEXTURE_WIDTH_RST  = 14'd256;
    localparam logic [13:0] TEXTURE_HEIGHT_RST = 14'd256;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH   = 2'd0,
        REG_SCREEN_HEIGHT  = 2'd1,
        REG_TEXTURE_WIDTH  = 2'd2,
        REG_TEXTURE_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [10:0] idx;
        logic        neg;
    } fold_t;

    typedef logic [14:0] sin_rom_t [QUARTER_TURN + 1];

    // angle in 0..5759 to a first-quadrant table index and a sign
    function automatic fold_t fold_angle(input logic [12:0] a);
        logic [12:0] r;
        logic [1:0]  q;
        fold_t       f;
        if (a >= ANGLE_Q3)
        begin
            q = 2'd3;
            r = a - ANGLE_Q3;
        end
        else if (a >= ANGLE_Q2)
        begin
            q = 2'd2;
            r = a - ANGLE_Q2;
        end
        else if (a >= ANGLE_Q1)
        begin
            q = 2'd1;
            r = a - ANGLE_Q1;
        end
        else
        begin
            q = 2'd0;
            r = a;
        end
        f.idx = q[0] ? 11'(ANGLE_Q1 - r) : r[10:0];
        f.neg = q[1];
        return f;
    endfunction

    // odd taylor polynomial in q30, result q1.14
    function automatic logic [14:0] quarter_sine(input int unsigned x);
        longint unsigned th;
        longint unsigned t2;
        longint unsigned p;
        longint unsigned s;
        th = (longint'(x) * PI_Q30 + 64'd1440) / 64'd2880;
        t2 = (th * th) >> 30;
        p  = ONE_Q30 - t2 / 64'd72;
        p  = ONE_Q30 - ((t2 * p) >> 30) / 64'd42;
        p  = ONE_Q30 - ((t2 * p) >> 30) / 64'd20;
        p  = ONE_Q30 - ((t2 * p) >> 30) / 64'd6;
        s  = (th * p) >> 30;
        return 15'((s + 64'd32768) >> 16);
    endfunction

    function automatic sin_rom_t build_sin_rom();
        sin_rom_t rom;
        for (int i = 0; i <= QUARTER_TURN; i++)
        begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

endpackage

// File: rtl/spqvt_div.sv
// ----------------------------------------------------------------------------
// spqvt divider
// pipelined restoring divider, one quotient bit per stage, 16-bit quotient
// with negative and overflow flags for saturation
// ----------------------------------------------------------------------------
module spqvt_div #(
    parameter int MW = 37,
    parameter int DW = 19
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [MW-1:0]                num,
    input  logic        [DW-1:0]                den,
    output logic        [spqvt_pkg::QUO_BITS-1:0] quo,
    output logic                                neg,
    output logic                                ovf
);

    localparam int NS = spqvt_pkg::DIV_STAGES;
    localparam int QB = spqvt_pkg::QUO_BITS;

    logic [MW-1:0] rem_reg [NS];
    logic [QB-1:0] q_reg   [NS];
    logic          neg_reg [NS];
    logic          ovf_reg [NS];
    logic [MW-1:0] den_w;

    assign den_w = MW'(den);

    // range check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[MW-1];
            ovf_reg[0] <= !num[MW-1] && (MW'(num) >= (den_w << QB));
        end
    end

    for (genvar j = 1; j < NS; j++)
    begin : g_stage
        localparam int B = QB - j;
        logic [MW-1:0] trial;
        logic          ge;

        assign trial = den_w << B;
        assign ge    = rem_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (ge ? (QB'(1) << B) : '0);
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo = q_reg[NS-1];
    assign neg = neg_reg[NS-1];
    assign ovf = ovf_reg[NS-1];

endmodule

// File: rtl/sprite_quad_vertex_transform_top.sv
// ----------------------------------------------------------------------------
// sprite quad vertex transform
// turns one sprite request into four rotated, scaled corners in ndc with
// normalized texture coordinates, in strip order
// ----------------------------------------------------------------------------
// One sprite word yields four vertex words, one per cycle when the vertex side
// keeps up, so a new sprite is taken only as the last corner of the previous
// one issues; the single vertex channel limits the sprite rate. After the
// request slot come five stages (angle fold, sine/cosine table read, products,
// sums and offset dividends), then a 17-stage divider pipeline per coordinate
// and an output register. A vertex stall freezes the whole pipeline; the
// request slot still takes a sprite while it is empty. Configuration is read
// by words already in flight, so the user must write it only while idle; the
// block itself does not enforce this.
module sprite_quad_vertex_transform_top #(
    parameter int COORD_FRACTION_BITS = spqvt_pkg::COORD_FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sprite_valid,
    output logic               sprite_stall,
    input  logic signed [15:0] dest_x,
    input  logic signed [15:0] dest_y,
    input  logic        [14:0] dest_width,
    input  logic        [14:0] dest_height,
    input  logic        [15:0] src_x,
    input  logic        [15:0] src_y,
    input  logic        [15:0] src_width,
    input  logic        [15:0] src_height,
    input  logic        [12:0] rotation,
    input  logic        [31:0] color_rgba,
    output logic               vertex_valid,
    input  logic               vertex_stall,
    output logic        [1:0]  corner,
    output logic               last_corner,
    output logic signed [15:0] ndc_x,
    output logic signed [15:0] ndc_y,
    output logic        [15:0] tex_u,
    output logic        [15:0] tex_v,
    output logic        [31:0] vertex_color,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [13:0] cfg_data
);

    localparam int DW = 15 + COORD_FRACTION_BITS;
    localparam int MW = (DW + 18 > 36) ? DW + 18 : 36;
    localparam int PW = 34;
    localparam int NS = spqvt_pkg::DIV_STAGES;
    localparam int QB = spqvt_pkg::QUO_BITS;
    localparam spqvt_pkg::sin_rom_t SIN_ROM = spqvt_pkg::build_sin_rom();

    // configuration
    logic [12:0] scr_w_reg;
    logic [12:0] scr_h_reg;
    logic [13:0] tex_w_reg;
    logic [13:0] tex_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= spqvt_pkg::SCREEN_WIDTH_RST;
            scr_h_reg <= spqvt_pkg::SCREEN_HEIGHT_RST;
            tex_w_reg <= spqvt_pkg::TEXTURE_WIDTH_RST;
            tex_h_reg <= spqvt_pkg::TEXTURE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (spqvt_pkg::cfg_reg_t'(cfg_index))
                spqvt_pkg::REG_SCREEN_WIDTH:   scr_w_reg <= cfg_data[12:0];
                spqvt_pkg::REG_SCREEN_HEIGHT:  scr_h_reg <= cfg_data[12:0];
                spqvt_pkg::REG_TEXTURE_WIDTH:  tex_w_reg <= cfg_data;
                spqvt_pkg::REG_TEXTURE_HEIGHT: tex_h_reg <= cfg_data;
                default:                       scr_w_reg <= scr_w_reg;
            endcase
        end
    end

    // doubled divisors, zero size acts as one
    logic [13:0]   nz_w;
    logic [13:0]   nz_h;
    logic [13:0]   nz_u;
    logic [13:0]   nz_v;
    logic [DW-1:0] den_x;
    logic [DW-1:0] den_y;
    logic [DW-1:0] den_u;
    logic [DW-1:0] den_v;

    assign nz_w  = (scr_w_reg == '0) ? 14'd1 : {1'b0, scr_w_reg};
    assign nz_h  = (scr_h_reg == '0) ? 14'd1 : {1'b0, scr_h_reg};
    assign nz_u  = (tex_w_reg == '0) ? 14'd1 : tex_w_reg;
    assign nz_v  = (tex_h_reg == '0) ? 14'd1 : tex_h_reg;
    assign den_x = DW'(nz_w) << (COORD_FRACTION_BITS + 1);
    assign den_y = DW'(nz_h) << (COORD_FRACTION_BITS + 1);
    assign den_u = DW'(nz_u) << (COORD_FRACTION_BITS + 1);
    assign den_v = DW'(nz_v) << (COORD_FRACTION_BITS + 1);

    // pipeline advance
    logic out_valid_reg;
    logic en;

    assign en = !(out_valid_reg && vertex_stall);

    // request slot and corner sequencer
    logic               slot_valid_reg;
    logic               slot_valid_next;
    logic [1:0]         k_reg;
    logic [1:0]         k_next;
    logic               accept;
    logic               issue_last;
    logic signed [15:0] dx0_reg;
    logic signed [15:0] dy0_reg;
    logic [14:0]        dw0_reg;
    logic [14:0]        dh0_reg;
    logic [15:0]        sx0_reg;
    logic [15:0]        sy0_reg;
    logic [15:0]        sw0_reg;
    logic [15:0]        sh0_reg;
    logic [12:0]        ang0_reg;
    logic [31:0]        col0_reg;

    assign issue_last   = en && slot_valid_reg && (k_reg == 2'd3);
    assign sprite_stall = slot_valid_reg && !issue_last;
    assign accept       = sprite_valid && !sprite_stall;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        k_next          = k_reg;
        if (en && slot_valid_reg)
        begin
            k_next = k_reg + 2'd1;
        end
        if (issue_last)
        begin
            slot_valid_next = 1'b0;
        end
        if (accept)
        begin
            slot_valid_next = 1'b1;
            k_next          = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            k_reg          <= 2'd0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx0_reg  <= dest_x;
            dy0_reg  <= dest_y;
            dw0_reg  <= dest_width;
            dh0_reg  <= dest_height;
            sx0_reg  <= src_x;
            sy0_reg  <= src_y;
            sw0_reg  <= src_width;
            sh0_reg  <= src_height;
            ang0_reg <= (rotation >= spqvt_pkg::ANGLE_FULL) ?
                        (rotation - spqvt_pkg::ANGLE_FULL) : rotation;
            col0_reg <= color_rgba;
        end
    end

    // stage 1: angle fold
    logic [12:0] cos_ang;
    logic [12:0] cos_sum;

    assign cos_sum = ang0_reg + spqvt_pkg::ANGLE_Q1;
    assign cos_ang = (cos_sum >= spqvt_pkg::ANGLE_FULL) ?
                     (cos_sum - spqvt_pkg::ANGLE_FULL) : cos_sum;

    logic                  v1_reg;
    logic [1:0]            k1_reg;
    spqvt_pkg::fold_t      sf1_reg;
    spqvt_pkg::fold_t      cf1_reg;
    logic signed [15:0]    dx1_reg;
    logic signed [15:0]    dy1_reg;
    logic [14:0]           dw1_reg;
    logic [14:0]           dh1_reg;
    logic [15:0]           sx1_reg;
    logic [15:0]           sy1_reg;
    logic [15:0]           sw1_reg;
    logic [15:0]           sh1_reg;
    logic [31:0]           col1_reg;

    // stage 2: table read
    logic                  v2_reg;
    logic [1:0]            k2_reg;
    logic [14:0]           sm2_reg;
    logic [14:0]           cm2_reg;
    logic                  sn2_reg;
    logic                  cn2_reg;
    logic signed [15:0]    dx2_reg;
    logic signed [15:0]    dy2_reg;
    logic [14:0]           dw2_reg;
    logic [14:0]           dh2_reg;
    logic [15:0]           sx2_reg;
    logic [15:0]           sy2_reg;
    logic [15:0]           sw2_reg;
    logic [15:0]           sh2_reg;
    logic [31:0]           col2_reg;

    // stage 3: products
    logic                  v3_reg;
    logic [1:0]            k3_reg;
    logic signed [31:0]    pxa3_reg;
    logic signed [31:0]    pxb3_reg;
    logic signed [31:0]    pya3_reg;
    logic signed [31:0]    pyb3_reg;
    logic signed [17:0]    bx3_reg;
    logic signed [17:0]    by3_reg;
    logic [16:0]           tun3_reg;
    logic [16:0]           tvn3_reg;
    logic [31:0]           col3_reg;

    // stage 4: sums
    logic                  v4_reg;
    logic [1:0]            k4_reg;
    logic signed [PW-1:0]  px4_reg;
    logic signed [PW-1:0]  py4_reg;
    logic [MW-1:0]         mu4_reg;
    logic [MW-1:0]         mv4_reg;
    logic [31:0]           col4_reg;

    // stage 5: offset dividends
    logic                  v5_reg;
    logic [1:0]            k5_reg;
    logic signed [MW-1:0]  mx5_reg;
    logic signed [MW-1:0]  my5_reg;
    logic signed [MW-1:0]  mu5_reg;
    logic signed [MW-1:0]  mv5_reg;
    logic [31:0]           col5_reg;

    // stage 3 operands
    logic signed [15:0]    sn_s;
    logic signed [15:0]    cs_s;
    logic signed [15:0]    hx_s;
    logic signed [15:0]    hy_s;
    logic signed [31:0]    sn_w;
    logic signed [31:0]    cs_w;
    logic signed [31:0]    hx_w;
    logic signed [31:0]    hy_w;
    logic signed [17:0]    dx_e;
    logic signed [17:0]    dy_e;

    assign sn_s = sn2_reg ? -$signed({1'b0, sm2_reg}) : $signed({1'b0, sm2_reg});
    assign cs_s = cn2_reg ? -$signed({1'b0, cm2_reg}) : $signed({1'b0, cm2_reg});
    assign hx_s = k2_reg[0] ? $signed({1'b0, dw2_reg}) : -$signed({1'b0, dw2_reg});
    assign hy_s = k2_reg[1] ? $signed({1'b0, dh2_reg}) : -$signed({1'b0, dh2_reg});
    assign sn_w = 32'(sn_s);
    assign cs_w = 32'(cs_s);
    assign hx_w = 32'(hx_s);
    assign hy_w = 32'(hy_s);
    assign dx_e = 18'(dx2_reg);
    assign dy_e = 18'(dy2_reg);

    // stage 4 operands
    logic signed [PW-1:0]  bx_p;
    logic signed [PW-1:0]  by_p;
    logic signed [PW-1:0]  pxa_p;
    logic signed [PW-1:0]  pxb_p;
    logic signed [PW-1:0]  pya_p;
    logic signed [PW-1:0]  pyb_p;

    assign bx_p  = PW'(bx3_reg);
    assign by_p  = PW'(by3_reg);
    assign pxa_p = PW'(pxa3_reg);
    assign pxb_p = PW'(pxb3_reg);
    assign pya_p = PW'(pya3_reg);
    assign pyb_p = PW'(pyb3_reg);

    // stage 5 operands
    logic signed [MW-1:0]  px_m;
    logic signed [MW-1:0]  py_m;

    assign px_m = MW'(px4_reg);
    assign py_m = MW'(py4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= slot_valid_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg   <= k_reg;
            sf1_reg  <= spqvt_pkg::fold_angle(ang0_reg);
            cf1_reg  <= spqvt_pkg::fold_angle(cos_ang);
            dx1_reg  <= dx0_reg;
            dy1_reg  <= dy0_reg;
            dw1_reg  <= dw0_reg;
            dh1_reg  <= dh0_reg;
            sx1_reg  <= sx0_reg;
            sy1_reg  <= sy0_reg;
            sw1_reg  <= sw0_reg;
            sh1_reg  <= sh0_reg;
            col1_reg <= col0_reg;

            k2_reg   <= k1_reg;
            sm2_reg  <= SIN_ROM[sf1_reg.idx];
            cm2_reg  <= SIN_ROM[cf1_reg.idx];
            sn2_reg  <= sf1_reg.neg;
            cn2_reg  <= cf1_reg.neg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            dw2_reg  <= dw1_reg;
            dh2_reg  <= dh1_reg;
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
            sw2_reg  <= sw1_reg;
            sh2_reg  <= sh1_reg;
            col2_reg <= col1_reg;

            k3_reg   <= k2_reg;
            pxa3_reg <= hx_w * cs_w;
            pxb3_reg <= hy_w * sn_w;
            pya3_reg <= hx_w * sn_w;
            pyb3_reg <= hy_w * cs_w;
            bx3_reg  <= (dx_e <<< 1) + $signed({3'b0, dw2_reg});
            by3_reg  <= (dy_e <<< 1) + $signed({3'b0, dh2_reg});
            tun3_reg <= {1'b0, sx2_reg} + (k2_reg[0] ? {1'b0, sw2_reg} : 17'd0);
            tvn3_reg <= {1'b0, sy2_reg} + (k2_reg[1] ? {1'b0, sh2_reg} : 17'd0);
            col3_reg <= col2_reg;

            k4_reg   <= k3_reg;
            px4_reg  <= (bx_p <<< 14) + pxa_p - pxb_p;
            py4_reg  <= (by_p <<< 14) + pya_p + pyb_p;
            mu4_reg  <= (MW'(tun3_reg) << 15) + MW'(den_u >> 1);
            mv4_reg  <= (MW'(tvn3_reg) << 15) + MW'(den_v >> 1);
            col4_reg <= col3_reg;

            k5_reg   <= k4_reg;
            mx5_reg  <= (px_m <<< 1) + $signed(MW'(den_x >> 1)) + $signed(MW'(den_x) << 14);
            my5_reg  <= (py_m <<< 1) + $signed(MW'(den_y >> 1)) + $signed(MW'(den_y) << 14);
            mu5_reg  <= mu4_reg;
            mv5_reg  <= mv4_reg;
            col5_reg <= col4_reg;
        end
    end

    // dividers
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [QB-1:0] qu;
    logic [QB-1:0] qv;
    logic          nx_neg;
    logic          ny_neg;
    logic          nu_neg;
    logic          nv_neg;
    logic          nx_ovf;
    logic          ny_ovf;
    logic          nu_ovf;
    logic          nv_ovf;

    spqvt_div #(.MW(MW), .DW(DW)) u_div_x (
        .clk (clk), .en (en), .num (mx5_reg), .den (den_x),
        .quo (qx), .neg (nx_neg), .ovf (nx_ovf)
    );

    spqvt_div #(.MW(MW), .DW(DW)) u_div_y (
        .clk (clk), .en (en), .num (my5_reg), .den (den_y),
        .quo (qy), .neg (ny_neg), .ovf (ny_ovf)
    );

    spqvt_div #(.MW(MW), .DW(DW)) u_div_u (
        .clk (clk), .en (en), .num (mu5_reg), .den (den_u),
        .quo (qu), .neg (nu_neg), .ovf (nu_ovf)
    );

    spqvt_div #(.MW(MW), .DW(DW)) u_div_v (
        .clk (clk), .en (en), .num (mv5_reg), .den (den_v),
        .quo (qv), .neg (nv_neg), .ovf (nv_ovf)
    );

    // side band alongside the dividers
    logic        vd_reg  [NS];
    logic [1:0]  kd_reg  [NS];
    logic [31:0] cd_reg  [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vd_reg[0] <= v5_reg;
            for (int i = 1; i < NS; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kd_reg[0] <= k5_reg;
            cd_reg[0] <= col5_reg;
            for (int i = 1; i < NS; i++)
            begin
                kd_reg[i] <= kd_reg[i-1];
                cd_reg[i] <= cd_reg[i-1];
            end
        end
    end

    // saturation
    logic [15:0] ndc_x_next;
    logic [15:0] ndc_y_next;
    logic [15:0] tex_u_next;
    logic [15:0] tex_v_next;

    always_comb
    begin
        if (nx_neg)
        begin
            ndc_x_next = 16'h8000;
        end
        else if (nx_ovf)
        begin
            ndc_x_next = 16'h7FFF;
        end
        else
        begin
            ndc_x_next = {~qx[15], qx[14:0]};
        end

        if (ny_neg || (!ny_ovf && qy == '0))
        begin
            ndc_y_next = 16'h7FFF;
        end
        else if (ny_ovf)
        begin
            ndc_y_next = 16'h8000;
        end
        else
        begin
            ndc_y_next = 16'(17'h08000 - {1'b0, qy});
        end

        tex_u_next = (nu_ovf || nu_neg) ? 16'hFFFF : qu;
        tex_v_next = (nv_ovf || nv_neg) ? 16'hFFFF : qv;
    end

    // output register
    logic [1:0]  corner_reg;
    logic [15:0] ndc_x_reg;
    logic [15:0] ndc_y_reg;
    logic [15:0] tex_u_reg;
    logic [15:0] tex_v_reg;
    logic [31:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vd_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corner_reg <= kd_reg[NS-1];
            ndc_x_reg  <= ndc_x_next;
            ndc_y_reg  <= ndc_y_next;
            tex_u_reg  <= tex_u_next;
            tex_v_reg  <= tex_v_next;
            color_reg  <= cd_reg[NS-1];
        end
    end

    assign vertex_valid = out_valid_reg;
    assign corner       = corner_reg;
    assign last_corner  = (corner_reg == 2'd3);
    assign ndc_x        = $signed(ndc_x_reg);
    assign ndc_y        = $signed(ndc_y_reg);
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign vertex_color = color_reg;

endmodule

// File: rtl/spqvt_checker.sv
// ----------------------------------------------------------------------------
// spqvt checker
// port-level properties of the sprite quad vertex transform, bound to the top
// ----------------------------------------------------------------------------
`include "sprite_quad_vertex_transform_top_defines.svh"

module spqvt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               vertex_valid,
    input logic               vertex_stall,
    input logic        [1:0]  corner,
    input logic               last_corner,
    input logic signed [15:0] ndc_x,
    input logic        [15:0] tex_u,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // stalled word holds
    `SPQVT_ASSERT_NEXT(a_vertex_hold, vertex_valid && vertex_stall, vertex_valid && $stable(corner) && $stable(ndc_x) && $stable(tex_u), "vertex word changed under stall")

    // marker sits on the fourth corner only
    `SPQVT_ASSERT_NOW(a_last_marker, vertex_valid, last_corner == (corner == 2'd3), "last_corner does not match corner")

    // corners of one sprite leave back to back
    `SPQVT_ASSERT_NEXT(a_corner_step, vertex_valid && !vertex_stall && !last_corner, vertex_valid && (corner == 2'($past(corner) + 2'd1)), "corner sequence broken")

    // register port never blocks
    `SPQVT_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind sprite_quad_vertex_transform_top spqvt_checker u_spqvt_checker (.*);

// File: verif/sprite_quad_vertex_transform_top_test.sv
// ----------------------------------------------------------------------------
// sprite quad vertex transform testbench
// drives sprite words under random gaps and vertex stalls, predicts the four
// corners of each sprite in fixed point and checks every vertex word in order
// ----------------------------------------------------------------------------
module sprite_quad_vertex_transform_top_test;

    typedef struct {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic        [14:0] dest_width;
        logic        [14:0] dest_height;
        logic        [15:0] src_x;
        logic        [15:0] src_y;
        logic        [15:0] src_width;
        logic        [15:0] src_height;
        logic        [12:0] rotation;
        logic        [31:0] color_rgba;
    } sprite_t;

    typedef struct {
        logic        [1:0]  corner;
        logic               last_corner;
        logic signed [15:0] ndc_x;
        logic signed [15:0] ndc_y;
        logic        [15:0] tex_u;
        logic        [15:0] tex_v;
        logic        [31:0] vertex_color;
    } vertex_t;

    logic               clk;
    logic               rst_n;
    logic               sprite_valid;
    logic               sprite_stall;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic        [14:0] dest_width;
    logic        [14:0] dest_height;
    logic        [15:0] src_x;
    logic        [15:0] src_y;
    logic        [15:0] src_width;
    logic        [15:0] src_height;
    logic        [12:0] rotation;
    logic        [31:0] color_rgba;
    logic               vertex_valid;
    logic               vertex_stall;
    logic        [1:0]  corner;
    logic               last_corner;
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic        [15:0] tex_u;
    logic        [15:0] tex_v;
    logic        [31:0] vertex_color;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [1:0]  cfg_index;
    logic        [13:0] cfg_data;

    sprite_t pending_sprites[$];
    vertex_t expected_vertices[$];

    int unsigned scr_w;
    int unsigned scr_h;
    int unsigned tex_w;
    int unsigned tex_h;

    int  error_count;
    int  sprite_gap;
    int  vertex_hold;
    int  long_hold;
    bit  sprite_taken;
    bit  sender_pause;

    sprite_quad_vertex_transform_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sprite_valid (sprite_valid),
        .sprite_stall (sprite_stall),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .dest_width   (dest_width),
        .dest_height  (dest_height),
        .src_x        (src_x),
        .src_y        (src_y),
        .src_width    (src_width),
        .src_height   (src_height),
        .rotation     (rotation),
        .color_rgba   (color_rgba),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .corner       (corner),
        .last_corner  (last_corner),
        .ndc_x        (ndc_x),
        .ndc_y        (ndc_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_color (vertex_color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // first-quadrant sine, q1.14, from an odd taylor series in q30
    function automatic longint quadrant_sine(longint unsigned x);
        longint unsigned th;
        longint unsigned t2;
        longint unsigned p;
        th = (x * spqvt_pkg::PI_Q30 + 64'd1440) / 64'd2880;
        t2 = (th * th) >> 30;
        p  = spqvt_pkg::ONE_Q30 - t2 / 64'd72;
        p  = spqvt_pkg::ONE_Q30 - ((t2 * p) >> 30) / 64'd42;
        p  = spqvt_pkg::ONE_Q30 - ((t2 * p) >> 30) / 64'd20;
        p  = spqvt_pkg::ONE_Q30 - ((t2 * p) >> 30) / 64'd6;
        return longint'((((th * p) >> 30) + 64'd32768) >> 16);
    endfunction

    function automatic longint angle_sine(longint unsigned a);
        longint unsigned q;
        longint unsigned r;
        longint          v;
        q = a / 1440;
        r = a % 1440;
        v = quadrant_sine(q[0] ? 1440 - r : r);
        return (q >= 2) ? -v : v;
    endfunction

    // rounds to nearest, halves toward plus infinity
    function automatic longint div_nearest(longint n, longint d);
        longint n2;
        longint d2;
        longint q;
        n2 = 2 * n + d;
        d2 = 2 * d;
        q  = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0)
            q--;
        return q;
    endfunction

    function automatic logic [15:0] clamp_s16(longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] clamp_u16(longint v);
        if (v > 65535)
            return 16'hffff;
        if (v < 0)
            return 16'h0000;
        return v[15:0];
    endfunction

    task automatic predict_corners(sprite_t s);
        longint  ang;
        longint  sn;
        longint  cs;
        longint  hx;
        longint  hy;
        longint  px;
        longint  py;
        longint  xs;
        longint  ys;
        longint  us;
        longint  vs;
        vertex_t v;
        xs  = longint'(((scr_w == 0) ? 1 : scr_w) * (1 << spqvt_pkg::COORD_FRACTION_BITS_DEF));
        ys  = longint'(((scr_h == 0) ? 1 : scr_h) * (1 << spqvt_pkg::COORD_FRACTION_BITS_DEF));
        us  = longint'(((tex_w == 0) ? 1 : tex_w) * (1 << spqvt_pkg::COORD_FRACTION_BITS_DEF));
        vs  = longint'(((tex_h == 0) ? 1 : tex_h) * (1 << spqvt_pkg::COORD_FRACTION_BITS_DEF));
        ang = longint'(s.rotation);
        if (ang >= 5760)
            ang -= 5760;
        sn = angle_sine(ang);
        cs = angle_sine((ang + 1440) % 5760);
        for (int k = 0; k < 4; k++)
        begin
            hx = k[0] ? longint'(s.dest_width) : -longint'(s.dest_width);
            hy = k[1] ? longint'(s.dest_height) : -longint'(s.dest_height);
            px = (2 * longint'(s.dest_x) + longint'(s.dest_width)) * 16384
                 + (hx * cs - hy * sn);
            py = (2 * longint'(s.dest_y) + longint'(s.dest_height)) * 16384
                 + (hx * sn + hy * cs);
            v.corner       = k[1:0];
            v.last_corner  = (k == 3);
            v.ndc_x        = clamp_s16(div_nearest(px, xs) - 16384);
            v.ndc_y        = clamp_s16(16384 - div_nearest(py, ys));
            v.tex_u        = clamp_u16(div_nearest((longint'(s.src_x)
                                 + (k[0] ? longint'(s.src_width) : 0)) * 16384, us));
            v.tex_v        = clamp_u16(div_nearest((longint'(s.src_y)
                                 + (k[1] ? longint'(s.src_height) : 0)) * 16384, vs));
            v.vertex_color = s.color_rgba;
            expected_vertices.push_back(v);
        end
    endtask

    // sprite side: acceptance at the rising edge, driving at the falling edge
    always @(posedge clk)
    begin
        sprite_t s;
        if (rst_n && sprite_valid && !sprite_stall)
        begin
            s.dest_x      = dest_x;
            s.dest_y      = dest_y;
            s.dest_width  = dest_width;
            s.dest_height = dest_height;
            s.src_x       = src_x;
            s.src_y       = src_y;
            s.src_width   = src_width;
            s.src_height  = src_height;
            s.rotation    = rotation;
            s.color_rgba  = color_rgba;
            predict_corners(s);
            sprite_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        sprite_t s;
        if (rst_n && !(sprite_valid && !sprite_taken))
        begin
            sprite_taken = 1'b0;
            if (sprite_gap > 0 || sender_pause || pending_sprites.size() == 0)
            begin
                if (sprite_gap > 0)
                    sprite_gap--;
                sprite_valid <= 1'b0;
            end
            else
            begin
                s = pending_sprites.pop_front();
                sprite_valid <= 1'b1;
                dest_x       <= s.dest_x;
                dest_y       <= s.dest_y;
                dest_width   <= s.dest_width;
                dest_height  <= s.dest_height;
                src_x        <= s.src_x;
                src_y        <= s.src_y;
                src_width    <= s.src_width;
                src_height   <= s.src_height;
                rotation     <= s.rotation;
                color_rgba   <= s.color_rgba;
                sprite_gap   = random_gap();
            end
        end
    end

    // vertex side
    always @(negedge clk)
    begin
        if (long_hold > 0)
        begin
            long_hold--;
            vertex_stall <= 1'b1;
        end
        else if (vertex_hold > 0)
        begin
            vertex_hold--;
            vertex_stall <= 1'b1;
        end
        else
        begin
            vertex_hold = random_gap();
            vertex_stall <= (vertex_hold > 0);
        end
    end

    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && vertex_valid && !vertex_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected vertex word, corner %0d", $time, corner);
            end
            else
            begin
                e = expected_vertices.pop_front();
                if (corner !== e.corner)
                begin
                    error_count++;
                    $display("%0t: corner expected %0d actual %0d", $time, e.corner, corner);
                end
                if (last_corner !== e.last_corner)
                begin
                    error_count++;
                    $display("%0t: last_corner expected %0d actual %0d",
                             $time, e.last_corner, last_corner);
                end
                if (ndc_x !== e.ndc_x)
                begin
                    error_count++;
                    $display("%0t: ndc_x expected %0d actual %0d", $time, e.ndc_x, ndc_x);
                end
                if (ndc_y !== e.ndc_y)
                begin
                    error_count++;
                    $display("%0t: ndc_y expected %0d actual %0d", $time, e.ndc_y, ndc_y);
                end
                if (tex_u !== e.tex_u)
                begin
                    error_count++;
                    $display("%0t: tex_u expected %0d actual %0d", $time, e.tex_u, tex_u);
                end
                if (tex_v !== e.tex_v)
                begin
                    error_count++;
                    $display("%0t: tex_v expected %0d actual %0d", $time, e.tex_v, tex_v);
                end
                if (vertex_color !== e.vertex_color)
                begin
                    error_count++;
                    $display("%0t: vertex_color expected %h actual %h",
                             $time, e.vertex_color, vertex_color);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_sprites.size() != 0 || sprite_valid || expected_vertices.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(spqvt_pkg::cfg_reg_t idx, logic [13:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            spqvt_pkg::REG_SCREEN_WIDTH:  scr_w = 32'(value[12:0]);
            spqvt_pkg::REG_SCREEN_HEIGHT: scr_h = 32'(value[12:0]);
            spqvt_pkg::REG_TEXTURE_WIDTH: tex_w = 32'(value);
            default:                      tex_h = 32'(value);
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [13:0] sw, logic [13:0] sh, logic [13:0] tw,
                             logic [13:0] th);
        write_reg(spqvt_pkg::REG_SCREEN_WIDTH, sw);
        write_reg(spqvt_pkg::REG_SCREEN_HEIGHT, sh);
        write_reg(spqvt_pkg::REG_TEXTURE_WIDTH, tw);
        write_reg(spqvt_pkg::REG_TEXTURE_HEIGHT, th);
    endtask

    function automatic sprite_t random_sprite();
        sprite_t s;
        s.dest_x      = 16'($urandom);
        s.dest_y      = 16'($urandom);
        s.dest_width  = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2047));
        s.dest_height = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2047));
        s.src_x       = 16'($urandom);
        s.src_y       = 16'($urandom);
        s.src_width   = 16'($urandom);
        s.src_height  = 16'($urandom);
        s.rotation    = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 5759));
        s.color_rgba  = $urandom;
        return s;
    endfunction

    task automatic add_sprite(int x, int y, int w, int h, int sx, int sy, int sw, int sh,
                              int rot, logic [31:0] col);
        sprite_t s;
        s.dest_x      = 16'(x);
        s.dest_y      = 16'(y);
        s.dest_width  = 15'(w);
        s.dest_height = 15'(h);
        s.src_x       = 16'(sx);
        s.src_y       = 16'(sy);
        s.src_width   = 16'(sw);
        s.src_height  = 16'(sh);
        s.rotation    = 13'(rot);
        s.color_rgba  = col;
        pending_sprites.push_back(s);
    endtask

    initial
    begin
        #(12 * 2000000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        sprite_valid = 1'b0;
        dest_x       = '0;
        dest_y       = '0;
        dest_width   = '0;
        dest_height  = '0;
        src_x        = '0;
        src_y        = '0;
        src_width    = '0;
        src_height   = '0;
        rotation     = '0;
        color_rgba   = '0;
        vertex_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = spqvt_pkg::REG_SCREEN_WIDTH;
        cfg_data     = '0;
        scr_w        = 1280;
        scr_h        = 720;
        tex_w        = 256;
        tex_h        = 256;
        error_count  = 0;
        sprite_gap   = 0;
        vertex_hold  = 0;
        long_hold    = 0;
        sprite_taken = 1'b0;
        sender_pause = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes, quadrant angles and out-of-range angles
        add_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0);
        add_sprite(-32768, -32768, 32767, 32767, 65535, 65535, 65535, 65535, 0, 32'hffffffff);
        add_sprite(32767, 32767, 32767, 32767, 0, 0, 65535, 65535, 5759, 32'h12345678);
        add_sprite(1600, 800, 512, 256, 128, 64, 256, 256, 1440, 32'haabbccdd);
        add_sprite(1600, 800, 512, 256, 128, 64, 256, 256, 2880, 32'h55aa55aa);
        add_sprite(1600, 800, 512, 256, 128, 64, 256, 256, 4320, 32'h01020304);
        add_sprite(1600, 800, 512, 256, 128, 64, 256, 256, 720, 32'hdeadbeef);
        add_sprite(1600, 800, 512, 256, 128, 64, 256, 256, 5760, 32'h0f0f0f0f);
        add_sprite(1600, 800, 512, 256, 128, 64, 256, 256, 8191, 32'hf0f0f0f0);
        add_sprite(1600, 800, 512, 256, 128, 64, 256, 256, 7200, 32'h80000001);
        add_sprite(-32768, 32767, 32767, 0, 65535, 0, 0, 65535, 1, 32'h7fffffff);
        add_sprite(10240, 5760, 1, 1, 4096, 4096, 1, 1, 1439, 32'hcafef00d);
        add_sprite(0, 0, 20480, 11520, 0, 0, 4096, 4096, 0, 32'h11111111);
        add_sprite(-16, -16, 16, 16, 8, 8, 8, 8, 2881, 32'h22222222);
        for (int i = 0; i < 6; i++)
            pending_sprites.push_back(random_sprite());
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       write_all(14'd1, 14'd1, 14'd1, 14'd1);
                1:       write_all(14'd4096, 14'd4096, 14'd8192, 14'd8192);
                2:       write_all(14'd0, 14'd0, 14'd0, 14'd0);
                3:       write_all(14'd16383, 14'd8191, 14'd16383, 14'd12345);
                4:       write_all(14'd1280, 14'd720, 14'd256, 14'd256);
                default: write_all(14'($urandom_range(1, 4096)), 14'($urandom_range(1, 4096)),
                                   14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
            endcase
            for (int i = 0; i < 65; i++)
                pending_sprites.push_back(random_sprite());
            if (ph == 1)
            begin
                // vertex side blocks long enough for the pipeline to back up
                @(negedge clk);
                long_hold = 300;
            end
            if (ph == 4)
            begin
                // sender halts mid-phase until every vertex word is out
                while (pending_sprites.size() > 30)
                    @(negedge clk);
                sender_pause = 1'b1;
                while (sprite_valid || expected_vertices.size() != 0)
                    @(negedge clk);
                sender_pause = 1'b0;
            end
            wait_drained();
        end

        repeat (60) @(negedge clk);
        if (error_count == 0 && expected_vertices.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
